[rtl/panel_switch_and_knob_decoder_assert.svh]
// Assertion macros shared by the panel decoder RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef PANEL_SWITCH_AND_KNOB_DECODER_ASSERT_SVH
`define PANEL_SWITCH_AND_KNOB_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PSK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psk: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PSK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psk: next-cycle check failed");

`endif

[rtl/psk_pkg.sv]
// Package for the panel switch and knob decoder: constants, types, Gray-code helpers.
// No dependencies.
package psk_pkg;

  // Quadrature phase codes, phase = {A, B}
  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_11 = 2'b11;
  localparam logic [1:0] PH_10 = 2'b10;

  localparam logic [3:0] STEP_THRESHOLD_RESET = 4'd4;

  // Control to each knob decoder
  typedef struct packed {
    logic       en;   // a scan moves into the result register
    logic [3:0] thr;  // step threshold
  } knob_ctrl_t;

  // Clockwise successor: 00 -> 01 -> 11 -> 10 -> 00
  function automatic logic [1:0] cw_next(input logic [1:0] ph);
    logic [1:0] nx;
    case (ph)
      PH_00:   nx = PH_01;
      PH_01:   nx = PH_11;
      PH_11:   nx = PH_10;
      PH_10:   nx = PH_00;
      default: nx = PH_00;
    endcase
    return nx;
  endfunction

  // +1 clockwise step, -1 anticlockwise, 0 for no change or a double jump
  function automatic logic signed [1:0] gray_delta(input logic [1:0] from_ph,
                                                   input logic [1:0] to_ph);
    logic signed [1:0] d;
    if (cw_next(from_ph) == to_ph) begin
      d = 2'sd1;
    end else if (cw_next(to_ph) == from_ph) begin
      d = -2'sd1;
    end else begin
      d = 2'sd0;
    end
    return d;
  endfunction

endpackage

[rtl/psk_knob.sv]
// One quadrature knob: phase, step count and position state.
// Depends on psk_pkg and panel_switch_and_knob_decoder_assert.svh.
`include "panel_switch_and_knob_decoder_assert.svh"

module psk_knob #(
  parameter int POSITIONS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psk_pkg::knob_ctrl_t     ctrl_i,
  input  logic [1:0]              phase_i,
  output logic [((POSITIONS > 1) ? $clog2(POSITIONS) : 1)-1:0] pos_next_o
);

  localparam int PosW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

  logic [1:0]          phase_q;
  logic signed [5:0]   cnt_q, cnt_d, cnt_sum;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PosW:0]       pos_inc;
  logic signed [5:0]   thr_s;

  // Count the Gray step, then step the position once the count passes the threshold
  always_comb begin
    thr_s   = $signed({2'b00, ctrl_i.thr});
    cnt_sum = cnt_q + 6'(psk_pkg::gray_delta(phase_q, phase_i));
    pos_inc = {1'b0, pos_q} + (PosW+1)'(1);
    cnt_d   = cnt_sum;
    pos_d   = pos_q;
    if (cnt_sum > thr_s) begin
      cnt_d = '0;
      pos_d = (pos_inc >= (PosW+1)'(POSITIONS)) ? '0 : pos_inc[PosW-1:0];
    end else if (cnt_sum < -thr_s) begin
      cnt_d = '0;
      pos_d = (pos_q == '0) ? PosW'(POSITIONS - 1) : pos_q - PosW'(1);
    end
  end

  assign pos_next_o = pos_d;

  // Knob state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= psk_pkg::PH_00;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else if (ctrl_i.en) begin
      phase_q <= phase_i;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  `PSK_ASSERT_NOW(a_cnt_range, 1'b1, (cnt_q <= 6'sd16) && (cnt_q >= -6'sd16))
  `PSK_ASSERT_NOW(a_pos_range, 1'b1, ({1'b0, pos_q} < (PosW+1)'(POSITIONS)))
  `PSK_ASSERT_NEXT(a_pos_hold, !ctrl_i.en, $stable(pos_q) && $stable(cnt_q))

endmodule

[rtl/panel_switch_and_knob_decoder.sv]
// Top level of the panel switch and knob decoder.
// Depends on psk_pkg, psk_knob and panel_switch_and_knob_decoder_assert.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | in_valid_i / in_stall_o    | matrix_row_0_i, _1_i, _2_i
//  out     | out_valid_o / out_stall_i  | sw_word_o ... button_presses_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_data_i (step threshold)
//
// A scan is captured in the input register; the decode logic and the knob state
// update then write the result register, from which the result is taken. One scan
// per cycle is sustained while out_stall_i is low.
// Reset clears edge history, knob state and valids and sets the threshold to 4.
// A stall on the output holds both registers and raises in_stall_o only while
// the input register is occupied.
`include "panel_switch_and_knob_decoder_assert.svh"

module panel_switch_and_knob_decoder #(
  parameter int KNOB1_POSITIONS = 8,
  parameter int KNOB2_POSITIONS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // scan input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] matrix_row_0_i,
  input  logic [11:0] matrix_row_1_i,
  input  logic [11:0] matrix_row_2_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] sw_word_o,
  output logic [7:0]  control_levels_o,
  output logic [7:0]  control_rising_o,
  output logic [7:0]  control_falling_o,
  output logic [2:0]  knob1_position_o,
  output logic [1:0]  knob2_position_o,
  output logic [1:0]  button_levels_o,
  output logic [1:0]  button_presses_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int K1W = (KNOB1_POSITIONS > 1) ? $clog2(KNOB1_POSITIONS) : 1;
  localparam int K2W = (KNOB2_POSITIONS > 1) ? $clog2(KNOB2_POSITIONS) : 1;

  logic        s1_valid_q, out_valid_q;
  logic [11:0] row0_q, row1_q, row2_q;
  logic        out_adv, s1_move, in_take;
  logic [3:0]  thr_q;
  logic [7:0]  ctl_prev_q, ctl_d;
  logic [1:0]  btn_prev_q, btn_d;
  psk_pkg::knob_ctrl_t knob_ctrl;
  logic [K1W-1:0] k1_pos_next;
  logic [K2W-1:0] k2_pos_next;

  // Handshake: result register frees when empty or taken
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  // Valid flags, edge history and threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_prev_q  <= '0;
      btn_prev_q  <= '0;
      thr_q       <= psk_pkg::STEP_THRESHOLD_RESET;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        ctl_prev_q <= ctl_d;
        btn_prev_q <= btn_d;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      row0_q <= matrix_row_0_i;
      row1_q <= matrix_row_1_i;
      row2_q <= matrix_row_2_i;
    end
  end

  // Decode of the registered scan
  assign ctl_d = ~row2_q[7:0];
  assign btn_d = row1_q[11:10];

  assign knob_ctrl.en  = s1_move;
  assign knob_ctrl.thr = thr_q;

  psk_knob #(
    .POSITIONS(KNOB1_POSITIONS)
  ) u_knob1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (knob_ctrl),
    .phase_i    ({row2_q[8], row2_q[9]}),
    .pos_next_o (k1_pos_next)
  );

  psk_knob #(
    .POSITIONS(KNOB2_POSITIONS)
  ) u_knob2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (knob_ctrl),
    .phase_i    ({row2_q[10], row2_q[11]}),
    .pos_next_o (k2_pos_next)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      sw_word_o         <= {row1_q[9:0], row0_q};
      control_levels_o  <= ctl_d;
      control_rising_o  <= ctl_d & ~ctl_prev_q;
      control_falling_o <= ~ctl_d & ctl_prev_q;
      knob1_position_o  <= 3'(k1_pos_next);
      knob2_position_o  <= 2'(k2_pos_next);
      button_levels_o   <= btn_d;
      button_presses_o  <= btn_d & ~btn_prev_q;
    end
  end

  `PSK_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q)
  `PSK_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid_q)
  `PSK_ASSERT_NEXT(a_cfg_written, cfg_valid_i, thr_q == $past(cfg_data_i))
  `PSK_ASSERT_NEXT(a_edge_hist, s1_move, ctl_prev_q == control_levels_o)

endmodule

[bench/tb_top.sv]
// Self-checking bench for panel_switch_and_knob_decoder: scan matrix decode, edges, knobs.
// Needs psk_pkg and the decoder RTL; predicts every result and compares it field by field.
// Directed scans come first, then random knob turning under several step thresholds.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOB1_POSITIONS = 8;
  localparam int KNOB2_POSITIONS = 4;
  localparam int GAP_MAX         = 18;
  localparam int HOLD_CYCLES     = 60;

  typedef struct {
    logic [21:0] sw;
    logic [7:0]  ctl;
    logic [7:0]  rise;
    logic [7:0]  fall;
    logic [2:0]  knob1;
    logic [1:0]  knob2;
    logic [1:0]  btn;
    logic [1:0]  press;
  } scan_result_t;

  // DUT signals, all inputs known from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [11:0] matrix_row_0_i = '0;
  logic [11:0] matrix_row_1_i = '0;
  logic [11:0] matrix_row_2_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [21:0] sw_word_o;
  logic [7:0]  control_levels_o;
  logic [7:0]  control_rising_o;
  logic [7:0]  control_falling_o;
  logic [2:0]  knob1_position_o;
  logic [1:0]  knob2_position_o;
  logic [1:0]  button_levels_o;
  logic [1:0]  button_presses_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i     = '0;

  // Predicted decoder state
  logic [3:0]   threshold_q = psk_pkg::STEP_THRESHOLD_RESET;
  logic [7:0]   ctl_prev    = '0;
  logic [1:0]   btn_prev    = '0;
  logic [1:0]   knob_phase [2];
  int           knob_count [2];
  int           knob_pos [2];
  scan_result_t pending_results [$];
  int           error_count = 0;

  // Stimulus control
  int         tx_gap_max = GAP_MAX;
  int         rx_gap_max = GAP_MAX;
  bit         hold_req   = 1'b0;
  logic [1:0] stim_phase [2];
  int         stim_dir [2];
  logic [7:0] stim_ctl   = '0;

  panel_switch_and_knob_decoder u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Position of a phase in the clockwise cycle 00 -> 01 -> 11 -> 10
  function automatic int cw_index(input logic [1:0] ph);
    int idx;
    case (ph)
      psk_pkg::PH_00: idx = 0;
      psk_pkg::PH_01: idx = 1;
      psk_pkg::PH_11: idx = 2;
      psk_pkg::PH_10: idx = 3;
      default:        idx = 0;
    endcase
    return idx;
  endfunction

  function automatic logic [1:0] cw_phase(input int idx);
    logic [1:0] ph;
    case (idx & 3)
      0:       ph = psk_pkg::PH_00;
      1:       ph = psk_pkg::PH_01;
      2:       ph = psk_pkg::PH_11;
      default: ph = psk_pkg::PH_10;
    endcase
    return ph;
  endfunction

  // +1 one place clockwise, -1 one place back, 0 for no move or a jump of two
  function automatic int quad_step(input logic [1:0] from_ph, input logic [1:0] to_ph);
    int steps;
    steps = (cw_index(to_ph) - cw_index(from_ph)) & 3;
    return (steps == 1) ? 1 : (steps == 3) ? -1 : 0;
  endfunction

  // Row 2: columns 0-7 control switches, 8/9 knob 1 A/B, 10/11 knob 2 A/B
  function automatic logic [11:0] knob_row(input logic [7:0] ctl_closed,
                                           input logic [1:0] ph1, input logic [1:0] ph2);
    return {ph2[0], ph2[1], ph1[0], ph1[1], ctl_closed};
  endfunction

  // Work out the result of one accepted scan and queue it
  task automatic decode_scan(input logic [11:0] r0, input logic [11:0] r1,
                             input logic [11:0] r2);
    scan_result_t res;
    logic [1:0]   ph [2];
    int           positions [2];
    int           thr;
    res.sw    = {r1[9:0], r0};
    res.ctl   = ~r2[7:0];
    res.rise  = res.ctl & ~ctl_prev;
    res.fall  = ~res.ctl & ctl_prev;
    res.btn   = r1[11:10];
    res.press = res.btn & ~btn_prev;
    ctl_prev  = res.ctl;
    btn_prev  = res.btn;
    ph[0] = {r2[8], r2[9]};
    ph[1] = {r2[10], r2[11]};
    positions[0] = KNOB1_POSITIONS;
    positions[1] = KNOB2_POSITIONS;
    thr = int'(threshold_q);
    for (int k = 0; k < 2; k++) begin
      knob_count[k] += quad_step(knob_phase[k], ph[k]);
      knob_phase[k] = ph[k];
      if (knob_count[k] > thr) begin
        knob_count[k] = 0;
        knob_pos[k] = (knob_pos[k] + 1) % positions[k];
      end else if (knob_count[k] < -thr) begin
        knob_count[k] = 0;
        knob_pos[k] = (knob_pos[k] + positions[k] - 1) % positions[k];
      end
    end
    res.knob1 = 3'(knob_pos[0]);
    res.knob2 = 2'(knob_pos[1]);
    pending_results.insert(pending_results.size(), res);
  endtask

  // Offer one scan after a random gap; returns at the edge that takes it
  task automatic send_scan(input logic [11:0] r0, input logic [11:0] r1,
                           input logic [11:0] r2);
    int gap;
    bit taken;
    gap = (tx_gap_max == 0 || $urandom_range(1, 0) == 0) ? 0 : $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    matrix_row_0_i <= r0;
    matrix_row_1_i <= r1;
    matrix_row_2_i <= r2;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    decode_scan(r0, r1, r2);
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [3:0] value);
    bit taken;
    go_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    threshold_q = value;
  endtask

  // Move both knobs by fixed steps, other switches random
  task automatic turn_knobs(input int d1, input int d2, input int n);
    for (int i = 0; i < n; i++) begin
      stim_phase[0] = cw_phase(cw_index(stim_phase[0]) + d1);
      stim_phase[1] = cw_phase(cw_index(stim_phase[1]) + d2);
      send_scan(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
                knob_row(8'($urandom_range(255, 0)), stim_phase[0], stim_phase[1]));
    end
  endtask

  // Mostly steady turning with direction changes, some pauses, jumps and noise
  task automatic send_random_scan();
    int roll;
    if ($urandom_range(3, 0) == 0) stim_ctl = 8'($urandom_range(255, 0));
    for (int k = 0; k < 2; k++) begin
      roll = $urandom_range(99, 0);
      if (roll < 5) stim_dir[k] = -stim_dir[k];
      if (roll < 70) begin
        stim_phase[k] = cw_phase(cw_index(stim_phase[k]) + stim_dir[k]);
      end else if (roll >= 85 && roll < 95) begin
        stim_phase[k] = cw_phase(cw_index(stim_phase[k]) + 2);
      end else if (roll >= 95) begin
        stim_phase[k] = 2'($urandom_range(3, 0));
      end
    end
    send_scan(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
              knob_row(stim_ctl, stim_phase[0], stim_phase[1]));
  endtask

  // First scan after reset, all-open and all-closed matrix, alternating bits, buttons
  task automatic test_scan_extremes();
    send_scan(12'h000, 12'h000, 12'h000);
    send_scan(12'hFFF, 12'hFFF, 12'hFFF);
    send_scan(12'hFFF, 12'hFFF, 12'hFFF);
    send_scan(12'hAAA, 12'h555, knob_row(8'hAA, psk_pkg::PH_01, psk_pkg::PH_10));
    send_scan(12'h555, 12'hAAA, knob_row(8'h55, psk_pkg::PH_00, psk_pkg::PH_11));
    send_scan(12'h000, 12'h000, 12'h000);
    stim_phase[0] = psk_pkg::PH_00;
    stim_phase[1] = psk_pkg::PH_00;
  endtask

  // Zero threshold: every step moves the position; knob 2 wraps down from 0
  task automatic test_threshold_zero();
    write_threshold(4'd0);
    turn_knobs(1, -1, 4);
    turn_knobs(-1, 1, 2);
  endtask

  // Threshold one: two steps per position; knob 1 wraps down through 0
  task automatic test_threshold_one();
    write_threshold(4'd1);
    turn_knobs(-1, -1, 6);
  endtask

  task automatic test_random_scans(input int n, input logic [3:0] thr, input int gap_max);
    write_threshold(thr);
    tx_gap_max = gap_max;
    rx_gap_max = gap_max;
    for (int i = 0; i < n; i++) send_random_scan();
  endtask

  // Receiver holds off for a long stretch while scans keep coming back to back
  task automatic test_backpressure();
    go_idle();
    tx_gap_max = 0;
    hold_req   = 1'b1;
    for (int i = 0; i < 30; i++) send_random_scan();
    tx_gap_max = GAP_MAX;
  endtask

  // Result side: random stalls per transaction, or one long hold on request
  initial begin : result_stall
    int  n;
    bit  taken;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (rx_gap_max == 0 || $urandom_range(1, 0) == 0) begin
        n = 0;
      end else begin
        n = $urandom_range(rx_gap_max, 0);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(negedge clk_i) begin : result_check
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: sw_word 0x%0h", sw_word_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("sw_word", want.sw, sw_word_o);
        check_field("control_levels", want.ctl, control_levels_o);
        check_field("control_rising", want.rise, control_rising_o);
        check_field("control_falling", want.fall, control_falling_o);
        check_field("knob1_position", want.knob1, knob1_position_o);
        check_field("knob2_position", want.knob2, knob2_position_o);
        check_field("button_levels", want.btn, button_levels_o);
        check_field("button_presses", want.press, button_presses_o);
      end
    end
  end

  initial begin
    for (int k = 0; k < 2; k++) begin
      knob_phase[k] = psk_pkg::PH_00;
      knob_count[k] = 0;
      knob_pos[k]   = 0;
      stim_phase[k] = psk_pkg::PH_00;
      stim_dir[k]   = 1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scan_extremes();
    test_threshold_zero();
    test_threshold_one();
    test_random_scans(150, 4'($urandom_range(14, 1)), GAP_MAX);
    test_random_scans(150, 4'd15, GAP_MAX);
    test_random_scans(100, 4'd1, 0);
    test_random_scans(100, 4'd0, GAP_MAX);
    test_backpressure();
    test_random_scans(100, psk_pkg::STEP_THRESHOLD_RESET, GAP_MAX);

    go_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** panel_switch_and_knob_decoder: PASSED **");
    end else begin
      $display("** panel_switch_and_knob_decoder: FAILED **");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #1_000_000;
    $display("** panel_switch_and_knob_decoder: FAILED **");
    $finish;
  end

endmodule
